// ----- rtl/gdsd_pkg.sv -----
// Shared types, constants and calendar helpers for the Gregorian date shift
// and distance core. No dependencies.

package gdsd_pkg;

    localparam int DW   = 5;   // day of month
    localparam int MW   = 4;   // month
    localparam int IYW  = 14;  // year as carried on the ports
    localparam int KW   = 16;  // day offset
    localparam int DSW  = 22;  // day distance
    localparam int STW  = 2;   // status
    localparam int OPW  = 2;   // opcode
    localparam int AW   = 25;  // signed day accumulator
    localparam int PW   = IYW; // completed years before a date
    localparam int Q1W  = 8;   // completed centuries
    localparam int Q4W  = 6;   // completed 400-year cycles
    localparam int RW   = 9;   // year position inside the 400-year cycle
    localparam int LYW  = 9;   // length of a year in days

    // Internal years hold an input year plus the farthest forward shift.
    localparam int YEAR_MIN_W = 15;

    localparam int YEAR_DAYS   = 365;
    localparam int CENTURY     = 100;
    localparam int CYCLE_YEARS = 400;
    localparam int MONTHS      = 12;
    localparam int LEAP_FEB    = 29;

    // Reciprocal of 25 in Q15; exact floor division for dividends below 4096.
    localparam int RECIP25       = 1311;
    localparam int RECIP25_SHIFT = 15;

    localparam logic [DSW-1:0] DIST_MAX = '1;

    typedef enum logic [OPW-1:0] {
        OP_BACK = 2'd0,
        OP_FWD  = 2'd1,
        OP_DIST = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [STW-1:0] {
        ST_OK       = 2'd0,
        ST_BAD_DATE = 2'd1,
        ST_ORDER    = 2'd2,
        ST_RANGE    = 2'd3
    } status_t;

    typedef struct packed {
        logic neg;  // sum is negative
        logic big;  // non-negative sum does not fit the distance field
    } alu_flags_t;

    localparam logic [DW-1:0] MONTH_DAYS [16] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
    };

    function automatic logic is_leap(input logic [RW-1:0] r);
        logic cent;
        begin
            cent = (r == RW'(CENTURY)) || (r == RW'(2 * CENTURY)) ||
                   (r == RW'(3 * CENTURY));
            is_leap = (r[1:0] == 2'b00) && !cent;
        end
    endfunction

    function automatic logic [DW-1:0] month_len(input logic [MW-1:0] m, input logic leap);
        logic [DW-1:0] n;
        begin
            n = MONTH_DAYS[m];
            if (m == MW'(2) && leap)
            begin
                n = DW'(LEAP_FEB);
            end
            month_len = n;
        end
    endfunction

endpackage

// ----- rtl/gdsd_alu.sv -----
// Shared add/subtract unit of the date core: every day count, day-count
// compare and month or year step goes through it. Depends on gdsd_pkg.

module gdsd_alu
    import gdsd_pkg::*;
(
    input  logic [AW-1:0] acc,
    input  logic [AW-1:0] operand,
    input  logic          sub,
    output logic [AW-1:0] sum,
    output alu_flags_t    flags
);

    always_comb
    begin
        sum       = sub ? (acc - operand) : (acc + operand);
        flags.neg = sum[AW-1];
        flags.big = |sum[AW-2:DSW];
    end

endmodule

// ----- rtl/gdsd_ysplit.sv -----
// Splits a count of completed years into centuries and 400-year cycles
// with constant reciprocal multiplies. Depends on gdsd_pkg.

module gdsd_ysplit
    import gdsd_pkg::*;
(
    input  logic [PW-1:0]  years,
    output logic [Q1W-1:0] centuries,
    output logic [Q4W-1:0] cycles
);

    localparam int P4W  = PW - 2;
    localparam int P16W = PW - 4;
    localparam int M1W  = P4W + 11;
    localparam int M4W  = P16W + 11;

    logic [M1W-1:0] prod_c;
    logic [M4W-1:0] prod_q;

    // years / 100 = (years / 4) / 25 and years / 400 = (years / 16) / 25.
    always_comb
    begin
        prod_c    = M1W'(years[PW-1:2]) * M1W'(RECIP25);
        prod_q    = M4W'(years[PW-1:4]) * M4W'(RECIP25);
        centuries = prod_c[RECIP25_SHIFT +: Q1W];
        cycles    = prod_q[RECIP25_SHIFT +: Q4W];
    end

endmodule

// ----- rtl/gregorian_date_shift_and_distance_core.sv -----
// Top level of the Gregorian date shift and distance core: sequencer and
// datapath registers. Depends on gdsd_pkg, gdsd_alu and gdsd_ysplit.
//
// Usage:
//   Input items arrive on item_valid / item_stall; item_stall is high while
//   an item is being worked, so one item is in the block at a time. Results
//   leave on result_valid / result_stall through an output register.
//   Opcode 0 shifts the first date back by offset_days, opcode 1 shifts it
//   forward, opcode 2 counts the days from the second date to the first.
//   All day-count arithmetic goes through one shared adder, one step per
//   cycle: for a distance, each date is turned into a day count by its year
//   terms and a walk over its months; a shift starts from the day of the year
//   and is resolved by stepping whole years, then months.
//   The next item is taken as soon as the result has moved to the output
//   register, even while the receiver still stalls it; the block waits in
//   its final state only when an older result is still held there.
//   Reset empties the output register and returns the sequencer to idle.

module gregorian_date_shift_and_distance_core
    import gdsd_pkg::*;
#(
    parameter int MAX_YEAR = 9999
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  logic [OPW-1:0]  opcode,
    input  logic [DW-1:0]   day_in,
    input  logic [MW-1:0]   month_in,
    input  logic [IYW-1:0]  year_in,
    input  logic [KW-1:0]   offset_days,
    input  logic [DW-1:0]   day_other,
    input  logic [MW-1:0]   month_other,
    input  logic [IYW-1:0]  year_other,
    output logic            result_valid,
    input  logic            result_stall,
    output logic [DW-1:0]   day_out,
    output logic [MW-1:0]   month_out,
    output logic [IYW-1:0]  year_out,
    output logic [DSW-1:0]  distance_days,
    output logic [STW-1:0]  status
);

    localparam int YW = ($clog2(MAX_YEAR + 1) > YEAR_MIN_W) ?
                        $clog2(MAX_YEAR + 1) : YEAR_MIN_W;

    typedef enum logic [14:0] {
        S_IDLE   = 15'b000000000000001,
        S_CHECK  = 15'b000000000000010,
        S_SPLIT  = 15'b000000000000100,
        S_BASE   = 15'b000000000001000,
        S_Y4     = 15'b000000000010000,
        S_Y100   = 15'b000000000100000,
        S_Y400   = 15'b000000001000000,
        S_DAYCHK = 15'b000000010000000,
        S_MSUM   = 15'b000000100000000,
        S_DSUM   = 15'b000001000000000,
        S_OFFS   = 15'b000010000000000,
        S_YWALK  = 15'b000100000000000,
        S_MWALK  = 15'b001000000000000,
        S_DIST   = 15'b010000000000000,
        S_FINISH = 15'b100000000000000
    } state_t;

    state_t          state_reg, state_next;
    logic            result_valid_reg, result_valid_next;

    op_t             op_reg, op_next;
    logic [KW-1:0]   k_reg, k_next;
    logic [DW-1:0]   cur_d_reg, cur_d_next;
    logic [MW-1:0]   cur_m_reg, cur_m_next;
    logic [YW-1:0]   cur_y_reg, cur_y_next;
    logic [DW-1:0]   oth_d_reg, oth_d_next;
    logic [MW-1:0]   oth_m_reg, oth_m_next;
    logic [IYW-1:0]  oth_y_reg, oth_y_next;
    logic            second_reg, second_next;
    logic [PW-1:0]   p_reg, p_next;
    logic [Q1W-1:0]  q100_reg, q100_next;
    logic [Q4W-1:0]  q400_reg, q400_next;
    logic [RW-1:0]   r400_reg, r400_next;
    logic [AW-1:0]   acc_reg, acc_next;
    logic [MW-1:0]   mi_reg, mi_next;

    logic [DW-1:0]   res_day_reg, res_day_next;
    logic [MW-1:0]   res_month_reg, res_month_next;
    logic [IYW-1:0]  res_year_reg, res_year_next;
    logic [DSW-1:0]  res_dist_reg, res_dist_next;
    status_t         res_status_reg, res_status_next;

    logic [DW-1:0]   day_out_reg, day_out_next;
    logic [MW-1:0]   month_out_reg, month_out_next;
    logic [IYW-1:0]  year_out_reg, year_out_next;
    logic [DSW-1:0]  dist_out_reg, dist_out_next;
    status_t         status_out_reg, status_out_next;

    logic [PW-1:0]   split_years;
    logic [Q1W-1:0]  split_cent;
    logic [Q4W-1:0]  split_cyc;
    logic [PW-1:0]   cycle_pos;
    logic [RW-1:0]   r400_init;
    logic [RW-1:0]   r400_prev;
    logic [RW-1:0]   r400_succ;
    logic            leap_cur;
    logic [LYW-1:0]  len_year_cur;
    logic [LYW-1:0]  len_year_prev;
    logic [DW-1:0]   len_mi;
    logic [DW-1:0]   len_cur_m;

    logic [AW-1:0]   alu_operand;
    logic            alu_sub;
    logic [AW-1:0]   alu_sum;
    alu_flags_t      alu_flags;

    assign split_years = PW'(cur_y_reg - YW'(1));

    gdsd_ysplit u_ysplit (
        .years     (split_years),
        .centuries (split_cent),
        .cycles    (split_cyc)
    );

    gdsd_alu u_alu (
        .acc     (acc_reg),
        .operand (alu_operand),
        .sub     (alu_sub),
        .sum     (alu_sum),
        .flags   (alu_flags)
    );

    // Calendar terms of the current year, tracked by its place in the
    // 400-year cycle so that year steps need no division.
    always_comb
    begin
        cycle_pos     = p_reg - PW'(q400_reg) * PW'(CYCLE_YEARS);
        r400_init     = (cycle_pos[RW-1:0] == RW'(CYCLE_YEARS - 1)) ?
                        '0 : cycle_pos[RW-1:0] + RW'(1);
        r400_prev     = (r400_reg == '0) ? RW'(CYCLE_YEARS - 1) : r400_reg - RW'(1);
        r400_succ     = (r400_reg == RW'(CYCLE_YEARS - 1)) ? '0 : r400_reg + RW'(1);
        leap_cur      = is_leap(r400_reg);
        len_year_cur  = leap_cur ? LYW'(YEAR_DAYS + 1) : LYW'(YEAR_DAYS);
        len_year_prev = is_leap(r400_prev) ? LYW'(YEAR_DAYS + 1) : LYW'(YEAR_DAYS);
        len_mi        = month_len(mi_reg, leap_cur);
        len_cur_m     = month_len(cur_m_reg, leap_cur);
    end

    // Operand selection for the shared adder. Day counts of the second date
    // are subtracted, so the accumulator ends at the distance.
    always_comb
    begin
        alu_operand = '0;
        alu_sub     = 1'b0;
        unique case (state_reg)
            S_BASE:
            begin
                alu_operand = AW'(p_reg) * AW'(YEAR_DAYS);
                alu_sub     = second_reg;
            end
            S_Y4:
            begin
                alu_operand = AW'(p_reg[PW-1:2]);
                alu_sub     = second_reg;
            end
            S_Y100:
            begin
                alu_operand = AW'(q100_reg);
                alu_sub     = !second_reg;
            end
            S_Y400:
            begin
                alu_operand = AW'(q400_reg);
                alu_sub     = second_reg;
            end
            S_MSUM:
            begin
                alu_operand = AW'(len_mi);
                alu_sub     = second_reg;
            end
            S_DSUM:
            begin
                alu_operand = AW'(cur_d_reg - DW'(1));
                alu_sub     = second_reg;
            end
            S_OFFS:
            begin
                alu_operand = AW'(k_reg);
                alu_sub     = (op_reg == OP_BACK);
            end
            S_YWALK:
            begin
                alu_operand = acc_reg[AW-1] ? AW'(len_year_prev) : AW'(len_year_cur);
                alu_sub     = !acc_reg[AW-1];
            end
            S_MWALK:
            begin
                alu_operand = AW'(len_mi);
                alu_sub     = 1'b1;
            end
            default:
            begin
                alu_operand = '0;
                alu_sub     = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next        = state_reg;
        result_valid_next = result_valid_reg;
        op_next           = op_reg;
        k_next            = k_reg;
        cur_d_next        = cur_d_reg;
        cur_m_next        = cur_m_reg;
        cur_y_next        = cur_y_reg;
        oth_d_next        = oth_d_reg;
        oth_m_next        = oth_m_reg;
        oth_y_next        = oth_y_reg;
        second_next       = second_reg;
        p_next            = p_reg;
        q100_next         = q100_reg;
        q400_next         = q400_reg;
        r400_next         = r400_reg;
        acc_next          = acc_reg;
        mi_next           = mi_reg;
        res_day_next      = res_day_reg;
        res_month_next    = res_month_reg;
        res_year_next     = res_year_reg;
        res_dist_next     = res_dist_reg;
        res_status_next   = res_status_reg;
        day_out_next      = day_out_reg;
        month_out_next    = month_out_reg;
        year_out_next     = year_out_reg;
        dist_out_next     = dist_out_reg;
        status_out_next   = status_out_reg;

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    op_next         = op_t'(opcode);
                    k_next          = offset_days;
                    cur_d_next      = day_in;
                    cur_m_next      = month_in;
                    cur_y_next      = YW'(year_in);
                    oth_d_next      = day_other;
                    oth_m_next      = month_other;
                    oth_y_next      = year_other;
                    second_next     = 1'b0;
                    acc_next        = '0;
                    res_day_next    = '0;
                    res_month_next  = '0;
                    res_year_next   = '0;
                    res_dist_next   = '0;
                    res_status_next = ST_OK;
                    state_next      = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (op_reg == OP_NONE || cur_m_reg == '0 || cur_m_reg > MW'(MONTHS) ||
                    cur_y_reg == '0 || cur_y_reg > YW'(MAX_YEAR))
                begin
                    res_status_next = ST_BAD_DATE;
                    state_next      = S_FINISH;
                end
                else
                begin
                    state_next = S_SPLIT;
                end
            end
            S_SPLIT:
            begin
                p_next     = split_years;
                q100_next  = split_cent;
                q400_next  = split_cyc;
                state_next = S_BASE;
            end
            S_BASE:
            begin
                r400_next = r400_init;
                if (op_reg == OP_DIST)
                begin
                    acc_next   = alu_sum;
                    state_next = S_Y4;
                end
                else
                begin
                    state_next = S_DAYCHK;
                end
            end
            S_Y4:
            begin
                acc_next   = alu_sum;
                state_next = S_Y100;
            end
            S_Y100:
            begin
                acc_next   = alu_sum;
                state_next = S_Y400;
            end
            S_Y400:
            begin
                acc_next   = alu_sum;
                state_next = S_DAYCHK;
            end
            S_DAYCHK:
            begin
                if (cur_d_reg == '0 || cur_d_reg > len_cur_m)
                begin
                    res_status_next = ST_BAD_DATE;
                    state_next      = S_FINISH;
                end
                else
                begin
                    mi_next    = MW'(1);
                    state_next = S_MSUM;
                end
            end
            S_MSUM:
            begin
                if (mi_reg < cur_m_reg)
                begin
                    acc_next = alu_sum;
                    mi_next  = mi_reg + MW'(1);
                end
                else
                begin
                    state_next = S_DSUM;
                end
            end
            S_DSUM:
            begin
                acc_next = alu_sum;
                if (op_reg != OP_DIST)
                begin
                    state_next = S_OFFS;
                end
                else if (!second_reg)
                begin
                    cur_d_next  = oth_d_reg;
                    cur_m_next  = oth_m_reg;
                    cur_y_next  = YW'(oth_y_reg);
                    second_next = 1'b1;
                    state_next  = S_CHECK;
                end
                else
                begin
                    state_next = S_DIST;
                end
            end
            S_OFFS:
            begin
                acc_next   = alu_sum;
                state_next = S_YWALK;
            end
            S_YWALK:
            begin
                // A negative day of year borrows the previous year; a day of
                // year past the year's length moves into the next year.
                if (acc_reg[AW-1])
                begin
                    if (cur_y_reg == YW'(1))
                    begin
                        res_status_next = ST_RANGE;
                        state_next      = S_FINISH;
                    end
                    else
                    begin
                        acc_next   = alu_sum;
                        cur_y_next = cur_y_reg - YW'(1);
                        r400_next  = r400_prev;
                    end
                end
                else if (!alu_flags.neg)
                begin
                    acc_next   = alu_sum;
                    cur_y_next = cur_y_reg + YW'(1);
                    r400_next  = r400_succ;
                end
                else
                begin
                    mi_next    = MW'(1);
                    state_next = S_MWALK;
                end
            end
            S_MWALK:
            begin
                if (mi_reg < MW'(MONTHS) && !alu_flags.neg)
                begin
                    acc_next = alu_sum;
                    mi_next  = mi_reg + MW'(1);
                end
                else
                begin
                    if (cur_y_reg > YW'(MAX_YEAR))
                    begin
                        res_status_next = ST_RANGE;
                    end
                    else
                    begin
                        res_day_next   = acc_reg[DW-1:0] + DW'(1);
                        res_month_next = mi_reg;
                        res_year_next  = cur_y_reg[IYW-1:0];
                    end
                    state_next = S_FINISH;
                end
            end
            S_DIST:
            begin
                // The adder passes the accumulator through unchanged here.
                if (alu_flags.neg)
                begin
                    res_status_next = ST_ORDER;
                end
                else if (alu_flags.big)
                begin
                    res_dist_next = DIST_MAX;
                end
                else
                begin
                    res_dist_next = alu_sum[DSW-1:0];
                end
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    day_out_next      = res_day_reg;
                    month_out_next    = res_month_reg;
                    year_out_next     = res_year_reg;
                    dist_out_next     = res_dist_reg;
                    status_out_next   = res_status_reg;
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        k_reg          <= k_next;
        cur_d_reg      <= cur_d_next;
        cur_m_reg      <= cur_m_next;
        cur_y_reg      <= cur_y_next;
        oth_d_reg      <= oth_d_next;
        oth_m_reg      <= oth_m_next;
        oth_y_reg      <= oth_y_next;
        second_reg     <= second_next;
        p_reg          <= p_next;
        q100_reg       <= q100_next;
        q400_reg       <= q400_next;
        r400_reg       <= r400_next;
        acc_reg        <= acc_next;
        mi_reg         <= mi_next;
        res_day_reg    <= res_day_next;
        res_month_reg  <= res_month_next;
        res_year_reg   <= res_year_next;
        res_dist_reg   <= res_dist_next;
        res_status_reg <= res_status_next;
        day_out_reg    <= day_out_next;
        month_out_reg  <= month_out_next;
        year_out_reg   <= year_out_next;
        dist_out_reg   <= dist_out_next;
        status_out_reg <= status_out_next;
    end

    assign item_stall    = (state_reg != S_IDLE);
    assign result_valid  = result_valid_reg;
    assign day_out       = day_out_reg;
    assign month_out     = month_out_reg;
    assign year_out      = year_out_reg;
    assign distance_days = dist_out_reg;
    assign status        = status_out_reg;

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for gregorian_date_shift_and_distance_core. It covers
// calendar edge cases first, then random traffic checked by a built-in predictor.
// Depends on gdsd_pkg and the core's RTL.

module tb
    import gdsd_pkg::*;
();

    localparam int     MAX_YEAR = 9999;
    localparam int     CLK_HALF = 2;
    localparam longint SPAN_CAP = (longint'(1) << DSW) - 1;
    localparam int     DRAIN_CYCLES = 300;
    localparam int     HOLD_OFF_CYCLES = 800;
    localparam int unsigned MONTH_LEN [1:12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    typedef struct packed {
        op_t            op;
        logic [DW-1:0]  day;
        logic [MW-1:0]  month;
        logic [IYW-1:0] year;
        logic [KW-1:0]  offset;
        logic [DW-1:0]  day2;
        logic [MW-1:0]  month2;
        logic [IYW-1:0] year2;
    } date_req_t;

    typedef struct packed {
        logic [DW-1:0]  day;
        logic [MW-1:0]  month;
        logic [IYW-1:0] year;
        logic [DSW-1:0] span;
        status_t        st;
    } date_res_t;

    logic           clk = 1'b0;
    logic           rst_n;
    logic           item_valid;
    logic           item_stall;
    logic [OPW-1:0] opcode;
    logic [DW-1:0]  day_in;
    logic [MW-1:0]  month_in;
    logic [IYW-1:0] year_in;
    logic [KW-1:0]  offset_days;
    logic [DW-1:0]  day_other;
    logic [MW-1:0]  month_other;
    logic [IYW-1:0] year_other;
    logic           result_valid;
    logic           result_stall;
    logic [DW-1:0]  day_out;
    logic [MW-1:0]  month_out;
    logic [IYW-1:0] year_out;
    logic [DSW-1:0] distance_days;
    logic [STW-1:0] status;

    date_res_t   expected_dates [$];
    int unsigned mismatch_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    bit          hold_req = 1'b0;
    bit          hold_taken = 1'b0;
    int unsigned hold_left = 0;

    gregorian_date_shift_and_distance_core #(.MAX_YEAR(MAX_YEAR)) dut (.*);

    always #(CLK_HALF) clk = ~clk;

    // Calendar arithmetic on a serial day count that starts at 1/1/1.
    function automatic bit leap_year(input int y);
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    function automatic int days_in(input int m, input int y);
        if (m == 2 && leap_year(y))
        begin
            return 29;
        end
        return MONTH_LEN[m];
    endfunction

    function automatic bit date_ok(input int d, input int m, input int y);
        if (m < 1 || m > 12 || y < 1 || y > MAX_YEAR)
        begin
            return 1'b0;
        end
        return d >= 1 && d <= days_in(m, y);
    endfunction

    function automatic longint day_number(input int d, input int m, input int y);
        longint p;
        longint n;
        p = longint'(y) - 1;
        n = p * 365 + p / 4 - p / 100 + p / 400;
        for (int i = 1; i < m; i++)
        begin
            n += days_in(i, y);
        end
        return n + longint'(d) - 1;
    endfunction

    function automatic void from_day_number(input longint n, output int d, output int m,
                                            output int y);
        longint r;
        // No year is longer than 366 days, so this first guess never overshoots.
        y = int'(n / 366) + 1;
        while (day_number(1, 1, y + 1) <= n)
        begin
            y++;
        end
        r = n - day_number(1, 1, y);
        m = 1;
        while (m < 12 && r >= days_in(m, y))
        begin
            r -= days_in(m, y);
            m++;
        end
        d = int'(r) + 1;
    endfunction

    function automatic date_res_t predict_date_result(input date_req_t rq);
        date_res_t res;
        longint    a;
        longint    b;
        longint    n;
        int        d;
        int        m;
        int        y;
        res = '0;
        res.st = ST_OK;
        if (rq.op == OP_NONE || !date_ok(rq.day, rq.month, rq.year) ||
            (rq.op == OP_DIST && !date_ok(rq.day2, rq.month2, rq.year2)))
        begin
            res.st = ST_BAD_DATE;
        end
        else if (rq.op == OP_DIST)
        begin
            a = day_number(rq.day, rq.month, rq.year);
            b = day_number(rq.day2, rq.month2, rq.year2);
            if (a < b)
            begin
                res.st = ST_ORDER;
            end
            else
            begin
                res.span = DSW'((a - b > SPAN_CAP) ? SPAN_CAP : a - b);
            end
        end
        else
        begin
            a = day_number(rq.day, rq.month, rq.year);
            n = (rq.op == OP_BACK) ? a - longint'(rq.offset) : a + longint'(rq.offset);
            if (n < 0)
            begin
                res.st = ST_RANGE;
            end
            else
            begin
                from_day_number(n, d, m, y);
                if (y > MAX_YEAR)
                begin
                    res.st = ST_RANGE;
                end
                else
                begin
                    res.day = DW'(d);
                    res.month = MW'(m);
                    res.year = IYW'(y);
                end
            end
        end
        return res;
    endfunction

    function automatic date_req_t make_request(input op_t op, input int d, input int m,
                                               input int y, input int k, input int d2,
                                               input int m2, input int y2);
        date_req_t rq;
        rq.op = op;
        rq.day = DW'(d);
        rq.month = MW'(m);
        rq.year = IYW'(y);
        rq.offset = KW'(k);
        rq.day2 = DW'(d2);
        rq.month2 = MW'(m2);
        rq.year2 = IYW'(y2);
        return rq;
    endfunction

    // Years lean toward both ends of the range and toward century years.
    function automatic int pick_year();
        case ($urandom_range(0, 9))
            0, 1:    return $urandom_range(1, 450);
            2, 3:    return $urandom_range(MAX_YEAR - 450, MAX_YEAR);
            4:       return $urandom_range(1, MAX_YEAR / 100) * 100;
            default: return $urandom_range(1, MAX_YEAR);
        endcase
    endfunction

    function automatic void random_date(input int y, output logic [DW-1:0] d,
                                        output logic [MW-1:0] m, output logic [IYW-1:0] yr);
        int len;
        m = MW'($urandom_range(1, 12));
        len = days_in(m, y);
        d = ($urandom_range(0, 4) == 0) ? DW'(len) : DW'($urandom_range(1, len));
        yr = IYW'(y);
    endfunction

    function automatic date_req_t random_request();
        date_req_t   rq;
        int unsigned pick;
        int          y2;
        rq.op = op_t'($urandom_range(0, 2));
        random_date(pick_year(), rq.day, rq.month, rq.year);
        pick = $urandom_range(0, 9);
        // Most offsets stay small since the block steps year by year.
        if (pick == 0)
        begin
            rq.offset = KW'($urandom);
        end
        else if (pick < 3)
        begin
            rq.offset = KW'($urandom_range(0, 40));
        end
        else
        begin
            rq.offset = KW'($urandom_range(0, 4000));
        end
        rq.day2 = DW'($urandom);
        rq.month2 = MW'($urandom);
        rq.year2 = IYW'($urandom);
        if (rq.op == OP_DIST)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                rq.day2 = rq.day;
                rq.month2 = rq.month;
                rq.year2 = rq.year;
            end
            else if (pick < 5)
            begin
                y2 = int'(rq.year) + int'($urandom_range(0, 2)) - 1;
                y2 = (y2 < 1) ? 1 : (y2 > MAX_YEAR) ? MAX_YEAR : y2;
                random_date(y2, rq.day2, rq.month2, rq.year2);
            end
            else
            begin
                random_date(pick_year(), rq.day2, rq.month2, rq.year2);
            end
        end
        // A share of items carries arbitrary bit patterns in the opcode, first date and offset.
        if ($urandom_range(0, 99) < 12)
        begin
            rq.op = op_t'($urandom_range(0, 3));
            rq.day = DW'($urandom);
            rq.month = MW'($urandom);
            rq.year = IYW'($urandom);
            rq.offset = KW'($urandom);
        end
        return rq;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer,
    // leaving item_valid high so that back-to-back items need no gap.
    task automatic send_request(input date_req_t rq);
        date_res_t want;
        want = predict_date_result(rq);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        opcode <= rq.op;
        day_in <= rq.day;
        month_in <= rq.month;
        year_in <= rq.year;
        offset_days <= rq.offset;
        day_other <= rq.day2;
        month_other <= rq.month2;
        year_other <= rq.year2;
        @(posedge clk);
        while (item_stall)
        begin
            @(posedge clk);
        end
        expected_dates.insert(expected_dates.size(), want);
        @(negedge clk);
    endtask

    task automatic test_shift_edges();
        send_request(make_request(OP_BACK, 1, 1, 1, 0, 0, 15, 16383));
        send_request(make_request(OP_BACK, 1, 1, 1, 1, 0, 0, 0));
        send_request(make_request(OP_FWD, 31, 12, MAX_YEAR, 0, 0, 0, 0));
        send_request(make_request(OP_FWD, 31, 12, MAX_YEAR, 1, 0, 0, 0));
        send_request(make_request(OP_FWD, 1, 1, 1, 65535, 31, 12, 1));
        send_request(make_request(OP_BACK, 31, 12, MAX_YEAR, 65535, 0, 0, 0));
        send_request(make_request(OP_FWD, 31, 12, 1999, 1, 0, 0, 0));
        send_request(make_request(OP_FWD, 15, 6, 9900, 65535, 0, 0, 0));
    endtask

    task automatic test_leap_rules();
        send_request(make_request(OP_FWD, 28, 2, 2000, 1, 0, 0, 0));
        send_request(make_request(OP_FWD, 28, 2, 1900, 1, 0, 0, 0));
        send_request(make_request(OP_FWD, 28, 2, 2024, 1, 0, 0, 0));
        send_request(make_request(OP_BACK, 1, 3, 2000, 1, 0, 0, 0));
        send_request(make_request(OP_BACK, 1, 3, 2100, 1, 0, 0, 0));
        send_request(make_request(OP_DIST, 1, 3, 2000, 0, 28, 2, 2000));
        send_request(make_request(OP_FWD, 29, 2, 2023, 0, 0, 0, 0));
    endtask

    task automatic test_invalid_inputs();
        send_request(make_request(OP_FWD, 0, 5, 2010, 3, 0, 0, 0));
        send_request(make_request(OP_BACK, 10, 0, 2010, 3, 0, 0, 0));
        send_request(make_request(OP_FWD, 10, 13, 2010, 3, 0, 0, 0));
        send_request(make_request(OP_DIST, 31, 15, 16383, 65535, 31, 15, 16383));
        send_request(make_request(OP_FWD, 1, 1, 0, 3, 0, 0, 0));
        send_request(make_request(OP_BACK, 1, 1, MAX_YEAR + 1, 3, 0, 0, 0));
        send_request(make_request(OP_FWD, 31, 4, 2010, 3, 0, 0, 0));
        send_request(make_request(OP_NONE, 1, 1, 2010, 3, 1, 1, 2000));
        send_request(make_request(OP_DIST, 1, 1, 2010, 0, 31, 2, 2000));
    endtask

    task automatic test_distance_cases();
        send_request(make_request(OP_DIST, 31, 12, MAX_YEAR, 0, 1, 1, 1));
        send_request(make_request(OP_DIST, 17, 8, 1234, 0, 17, 8, 1234));
        send_request(make_request(OP_DIST, 1, 1, 1, 0, 31, 12, MAX_YEAR));
    endtask

    task automatic test_random_traffic(input int count, input int unsigned send_pct,
                                       input int unsigned recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count)
        begin
            send_request(random_request());
        end
    endtask

    // The receiver stops taking results for a long stretch while items keep
    // coming, so the output register and the sequencer both fill up.
    task automatic test_output_hold_off();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b1;
        repeat (20)
        begin
            send_request(random_request());
        end
    endtask

    always @(negedge clk)
    begin
        if (hold_req && !hold_taken)
        begin
            hold_left = HOLD_OFF_CYCLES;
            hold_taken = 1'b1;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        date_res_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_dates.size() == 0)
            begin
                $error("result transfer with no expected result pending");
                mismatch_count++;
            end
            else
            begin
                want = expected_dates.pop_front();
                if (day_out !== want.day)
                begin
                    $error("day_out: expected %0d, got %0d", want.day, day_out);
                    mismatch_count++;
                end
                if (month_out !== want.month)
                begin
                    $error("month_out: expected %0d, got %0d", want.month, month_out);
                    mismatch_count++;
                end
                if (year_out !== want.year)
                begin
                    $error("year_out: expected %0d, got %0d", want.year, year_out);
                    mismatch_count++;
                end
                if (distance_days !== want.span)
                begin
                    $error("distance_days: expected %0d, got %0d", want.span, distance_days);
                    mismatch_count++;
                end
                if (status !== want.st)
                begin
                    $error("status: expected %0d, got %0d", want.st, status);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        opcode = OP_BACK;
        day_in = '0;
        month_in = '0;
        year_in = '0;
        offset_days = '0;
        day_other = '0;
        month_other = '0;
        year_other = '0;
        repeat (3)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 17;
        recv_idle_pct = 66;
        test_shift_edges();
        test_leap_rules();
        test_invalid_inputs();
        test_distance_cases();
        test_random_traffic(600, 17, 66);
        test_random_traffic(600, 66, 17);
        test_random_traffic(580, 0, 0);
        test_output_hold_off();

        item_valid <= 1'b0;
        recv_idle_pct = 0;
        while (expected_dates.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES)
        begin
            @(posedge clk);
        end
        if (mismatch_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/gdsd_pkg.sv
rtl/gdsd_alu.sv
rtl/gdsd_ysplit.sv
rtl/gregorian_date_shift_and_distance_core.sv
sim/tb.sv
